// ===== design/cscl_pkg.sv =====
// Package with shared types and constants of the cone side cluster labeler.
package cscl_pkg;
    localparam int MAX_CONES  = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_CONES);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int LINK_BITS  = 15;
    localparam int DIST_BITS  = 2 * COORD_BITS + 2;
    localparam logic [LINK_BITS-1:0] LINK_RESET = LINK_BITS'(1024);

    localparam logic [2:0] LABEL_NONE         = 3'd0;
    localparam logic [2:0] LABEL_LEFT_SEED    = 3'd1;
    localparam logic [2:0] LABEL_RIGHT_SEED   = 3'd2;
    localparam logic [2:0] LABEL_LEFT_MEMBER  = 3'd3;
    localparam logic [2:0] LABEL_RIGHT_MEMBER = 3'd4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cone_x;
        logic signed [COORD_BITS-1:0] cone_y;
        logic                         frame_end;
    } cone_in_t;

    typedef struct packed {
        logic [5:0]                   cone_number;
        logic [2:0]                   side_label;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic                         frame_overflow;
        logic                         result_last;
    } label_out_t;

    // Controller commands to the datapath.
    typedef struct packed {
        logic                store;     // write input cone at count
        logic                clr_count; // frame done
        logic                seed_init;
        logic                seed_step; // evaluate cone at index a
        logic                grow_init; // set masks to seeds
        logic                grow_step; // test pair (a,b)
        logic                side;      // 0 left, 1 right
        logic [IDX_BITS-1:0] idx_a;
        logic [IDX_BITS-1:0] idx_b;
        logic                clr_change;
    } cscl_cmd_t;

    typedef struct packed {
        logic [CNT_BITS-1:0] count;
        logic                changed;
    } cscl_sts_t;
endpackage

// ===== design/cscl_datapath.sv =====
// Datapath: cone stores, seed search, region growing and label forming.
module cscl_datapath import cscl_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cone_in_t             in_data,
    input  logic [LINK_BITS-1:0] link_distance,
    input  cscl_cmd_t            cmd,
    output cscl_sts_t            sts,
    output label_out_t           label
);
    logic signed [COORD_BITS-1:0] x_mem [MAX_CONES];
    logic signed [COORD_BITS-1:0] y_mem [MAX_CONES];
    logic signed [COORD_BITS-1:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic [CNT_BITS-1:0]  count_reg;
    logic                 ovf_reg;
    logic [MAX_CONES-1:0] lmask_reg, rmask_reg;
    logic                 lvalid_reg, rvalid_reg;
    logic [IDX_BITS-1:0]  lseed_reg, rseed_reg;
    logic [DIST_BITS-1:0] lbest_reg, rbest_reg;
    logic                 changed_reg;
    // Pipeline: read, squares, compare.
    logic                 v1_reg, v2_reg;
    logic                 side1_reg, side2_reg, seed1_reg, seed2_reg;
    logic [IDX_BITS-1:0]  ia1_reg, ib1_reg, ia2_reg, ib2_reg;
    logic [DIST_BITS-1:0] sqa_reg, sqb_reg;
    logic                 lq2_reg, rq2_reg;
    logic [DIST_BITS-1:0] lim_reg;

    logic signed [COORD_BITS:0] dx, dy, ax, ay;
    logic lq, rq;

    always_ff @(posedge aclk) begin
        if (cmd.store && !count_reg[IDX_BITS]) begin
            x_mem[count_reg[IDX_BITS-1:0]] <= in_data.cone_x;
            y_mem[count_reg[IDX_BITS-1:0]] <= in_data.cone_y;
        end
        xa_reg <= x_mem[cmd.idx_a];
        ya_reg <= y_mem[cmd.idx_a];
        xb_reg <= x_mem[cmd.idx_b];
        yb_reg <= y_mem[cmd.idx_b];
    end

    // Seed step uses distance to origin; grow step uses pair distance.
    always_comb begin
        if (seed1_reg) begin
            dx = {xa_reg[COORD_BITS-1], xa_reg};
            dy = {ya_reg[COORD_BITS-1], ya_reg};
        end else begin
            dx = {xa_reg[COORD_BITS-1], xa_reg} - {xb_reg[COORD_BITS-1], xb_reg};
            dy = {ya_reg[COORD_BITS-1], ya_reg} - {yb_reg[COORD_BITS-1], yb_reg};
        end
        ax = dx[COORD_BITS] ? -dx : dx;
        ay = dy[COORD_BITS] ? -dy : dy;
        lq = (!ya_reg[COORD_BITS-1] && !xa_reg[COORD_BITS-1] && xa_reg != '0)
             || (xa_reg == '0 && ya_reg == '0);
        rq = ya_reg[COORD_BITS-1] && !xa_reg[COORD_BITS-1];
    end

    logic [DIST_BITS-1:0] d2;
    assign d2 = sqa_reg + sqb_reg;

    always_ff @(posedge aclk) begin
        lim_reg   <= DIST_BITS'((2*LINK_BITS)'(link_distance)
                                * (2*LINK_BITS)'(link_distance));
        ia1_reg   <= cmd.idx_a;
        ib1_reg   <= cmd.idx_b;
        side1_reg <= cmd.side;
        seed1_reg <= cmd.seed_step;
        ia2_reg   <= ia1_reg;
        ib2_reg   <= ib1_reg;
        side2_reg <= side1_reg;
        seed2_reg <= seed1_reg;
        sqa_reg   <= DIST_BITS'((2*COORD_BITS)'(ax[COORD_BITS-1:0])
                                * (2*COORD_BITS)'(ax[COORD_BITS-1:0]))
                   + (ax[COORD_BITS] ? DIST_BITS'(1) << (2*COORD_BITS) : '0);
        sqb_reg   <= DIST_BITS'((2*COORD_BITS)'(ay[COORD_BITS-1:0])
                                * (2*COORD_BITS)'(ay[COORD_BITS-1:0]))
                   + (ay[COORD_BITS] ? DIST_BITS'(1) << (2*COORD_BITS) : '0);
        lq2_reg   <= lq;
        rq2_reg   <= rq;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            lmask_reg   <= '0;
            rmask_reg   <= '0;
            lvalid_reg  <= 1'b0;
            rvalid_reg  <= 1'b0;
            changed_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
        end else begin
            v1_reg <= cmd.seed_step || cmd.grow_step;
            v2_reg <= v1_reg;
            if (cmd.store) begin
                if (count_reg[IDX_BITS]) ovf_reg <= 1'b1;
                else count_reg <= count_reg + CNT_BITS'(1);
            end
            if (cmd.clr_count) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.seed_init) begin
                lvalid_reg <= 1'b0;
                rvalid_reg <= 1'b0;
            end
            if (cmd.clr_change) changed_reg <= 1'b0;
            if (cmd.grow_init) begin
                lmask_reg <= '0;
                rmask_reg <= '0;
                if (lvalid_reg) lmask_reg[lseed_reg] <= 1'b1;
                if (rvalid_reg) rmask_reg[rseed_reg] <= 1'b1;
            end
            if (v2_reg && seed2_reg) begin
                if (lq2_reg && (!lvalid_reg || d2 < lbest_reg)) begin
                    lvalid_reg <= 1'b1;
                    lbest_reg  <= d2;
                    lseed_reg  <= ia2_reg;
                end
                if (rq2_reg && (!rvalid_reg || d2 < rbest_reg)) begin
                    rvalid_reg <= 1'b1;
                    rbest_reg  <= d2;
                    rseed_reg  <= ia2_reg;
                end
            end
            // Adding b when a is a member; membership order does not matter
            // since iteration continues until nothing changes.
            if (v2_reg && !seed2_reg && d2 <= lim_reg) begin
                if (!side2_reg) begin
                    if (lmask_reg[ia2_reg] && !lmask_reg[ib2_reg]) begin
                        lmask_reg[ib2_reg] <= 1'b1;
                        changed_reg <= 1'b1;
                    end
                end else if (rmask_reg[ia2_reg] && !rmask_reg[ib2_reg]) begin
                    rmask_reg[ib2_reg] <= 1'b1;
                    changed_reg <= 1'b1;
                end
            end
        end
    end

    // Label formed from the registered read of the cone at idx_b (ib1).
    always_comb begin
        label.cone_number    = 6'(ib1_reg);
        label.pos_x          = xb_reg;
        label.pos_y          = yb_reg;
        label.frame_overflow = ovf_reg;
        label.result_last    = (CNT_BITS'(ib1_reg) + CNT_BITS'(1)) == count_reg;
        if (lvalid_reg && ib1_reg == lseed_reg)      label.side_label = LABEL_LEFT_SEED;
        else if (rvalid_reg && ib1_reg == rseed_reg) label.side_label = LABEL_RIGHT_SEED;
        else if (lmask_reg[ib1_reg])                 label.side_label = LABEL_LEFT_MEMBER;
        else if (rmask_reg[ib1_reg])                 label.side_label = LABEL_RIGHT_MEMBER;
        else                                         label.side_label = LABEL_NONE;
    end

    assign sts.count   = count_reg;
    assign sts.changed = changed_reg;
endmodule

// ===== design/cscl_ctrl.sv =====
// Controller state machine that sequences loading, seeding, growing and output.
module cscl_ctrl import cscl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      frame_end,
    output logic      m_valid,
    input  logic      m_ready,
    input  cscl_sts_t sts,
    output cscl_cmd_t cmd
);
    typedef enum logic [2:0] {
        ST_LOAD, ST_SEED, ST_GROW, ST_DRAIN, ST_EMIT_RD, ST_EMIT
    } state_t;

    state_t              state_reg;
    logic [IDX_BITS-1:0] a_reg, b_reg;
    logic                side_reg;
    logic [1:0]          wait_reg;

    logic [IDX_BITS-1:0] last;
    assign last = IDX_BITS'(sts.count - CNT_BITS'(1));

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_EMIT);

    always_comb begin
        cmd            = '0;
        cmd.idx_a      = a_reg;
        cmd.idx_b      = b_reg;
        cmd.side       = side_reg;
        cmd.store      = s_valid && s_ready;
        cmd.seed_init  = s_valid && s_ready && frame_end;
        cmd.seed_step  = (state_reg == ST_SEED);
        cmd.grow_step  = (state_reg == ST_GROW);
        cmd.grow_init  = (state_reg == ST_DRAIN) && wait_reg == 2'd0 && !side_reg
                         && !sts.changed && b_reg == '1;
        cmd.clr_change = (state_reg == ST_GROW) && a_reg == '0 && b_reg == '0;
        cmd.clr_count  = (state_reg == ST_EMIT) && m_ready && b_reg == last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            a_reg     <= '0;
            b_reg     <= '0;
            side_reg  <= 1'b0;
            wait_reg  <= '0;
        end else begin
            case (state_reg)
                ST_LOAD: begin
                    if (s_valid && frame_end) begin
                        state_reg <= ST_SEED;
                        a_reg     <= '0;
                    end
                end
                ST_SEED: begin
                    if (a_reg == last) begin
                        state_reg <= ST_DRAIN;
                        wait_reg  <= 2'd3;
                        b_reg     <= '1; // marks seed drain
                        side_reg  <= 1'b0;
                    end else begin
                        a_reg <= a_reg + IDX_BITS'(1);
                    end
                end
                ST_GROW: begin
                    if (b_reg == last) begin
                        b_reg <= '0;
                        if (a_reg == last) begin
                            state_reg <= ST_DRAIN;
                            wait_reg  <= 2'd3;
                        end else begin
                            a_reg <= a_reg + IDX_BITS'(1);
                        end
                    end else begin
                        b_reg <= b_reg + IDX_BITS'(1);
                    end
                end
                ST_DRAIN: begin
                    if (wait_reg != 2'd0) begin
                        wait_reg <= wait_reg - 2'd1;
                    end else if (b_reg == '1 && !side_reg) begin
                        // Seed phase done: masks loaded, start left grow.
                        state_reg <= ST_GROW;
                        a_reg     <= '0;
                        b_reg     <= '0;
                    end else if (sts.changed) begin
                        state_reg <= ST_GROW;
                        a_reg     <= '0;
                        b_reg     <= '0;
                    end else if (!side_reg) begin
                        side_reg  <= 1'b1;
                        state_reg <= ST_GROW;
                        a_reg     <= '0;
                        b_reg     <= '0;
                    end else begin
                        state_reg <= ST_EMIT_RD;
                        b_reg     <= '0;
                    end
                end
                ST_EMIT_RD: begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        if (b_reg == last) begin
                            state_reg <= ST_LOAD;
                        end else begin
                            b_reg     <= b_reg + IDX_BITS'(1);
                            state_reg <= ST_EMIT_RD;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end
endmodule

// ===== design/cone_side_cluster_labeler.sv =====
// Top level of the cone side cluster labeler.
// Loading: one cone per cycle while s_ready is high. On frame end, the seed search runs,
// then grow passes per side repeat until no cone joins, then labels go out one at a time.
// Throughput is set by the shared squared-distance unit, one cone pair per cycle.
// Reset (aresetn, synchronous, active low) empties the frame, clears the masks
// and seeds, and sets link_distance to 1024.
module cone_side_cluster_labeler import cscl_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  cone_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output label_out_t           m_data,
    input  logic                 cfg_we,
    input  logic [LINK_BITS-1:0] cfg_data
);
    logic [LINK_BITS-1:0] link_reg;
    cscl_cmd_t cmd;
    cscl_sts_t sts;

    always_ff @(posedge aclk) begin
        if (!aresetn) link_reg <= LINK_RESET;
        else if (cfg_we) link_reg <= cfg_data;
    end

    cscl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .frame_end(s_data.frame_end), .m_valid(m_valid), .m_ready(m_ready),
        .sts(sts), .cmd(cmd)
    );

    cscl_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_data(s_data), .link_distance(link_reg),
        .cmd(cmd), .sts(sts), .label(m_data)
    );

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.count <= CNT_BITS'(MAX_CONES)) else $error("cone count beyond capacity");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("load and emit overlap");
    a_last_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.result_last |=> s_ready)
        else $error("frame did not end after last label");
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the cone side cluster labeler, with a scoreboard that predicts labels.
import cscl_pkg::*;

class label_scoreboard;
    logic signed [COORD_BITS-1:0] x_mem[MAX_CONES];
    logic signed [COORD_BITS-1:0] y_mem[MAX_CONES];
    int                           stored;
    bit                           dropped;
    logic [LINK_BITS-1:0]         link;
    label_out_t                   label_q[$];
    int                           errors;

    function new();
        stored  = 0;
        dropped = 0;
        link    = LINK_RESET;
        errors  = 0;
    endfunction

    function int pending();
        return label_q.size();
    endfunction

    function longint sq_dist(longint ax, longint ay, longint bx, longint by);
        return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    // Closure of all cones reachable from the seed by hops within the link distance.
    function logic [63:0] grow_cluster(int seed);
        logic [63:0] set;
        longint      lim;
        bit          changed;
        if (seed < 0) return '0;
        set = '0;
        set[seed] = 1'b1;
        lim = longint'(link) * longint'(link);
        changed = 1;
        while (changed) begin
            changed = 0;
            for (int i = 0; i < stored; i++) begin
                if (!set[i]) continue;
                for (int j = 0; j < stored; j++) begin
                    if (set[j]) continue;
                    if (sq_dist(x_mem[i], y_mem[i], x_mem[j], y_mem[j]) <= lim) begin
                        set[j] = 1'b1;
                        changed = 1;
                    end
                end
            end
        end
        return set;
    endfunction

    function void predict_frame();
        int          lseed, rseed;
        longint      lbest, rbest, d;
        longint      x, y;
        logic [63:0] lmask, rmask;
        label_out_t  lab;
        lseed = -1;
        rseed = -1;
        lbest = 0;
        rbest = 0;
        for (int i = 0; i < stored; i++) begin
            x = x_mem[i];
            y = y_mem[i];
            d = x * x + y * y;
            if ((y >= 0 && x > 0) || (x == 0 && y == 0)) begin
                if (lseed < 0 || d < lbest) begin
                    lseed = i;
                    lbest = d;
                end
            end
            if (y < 0 && x >= 0) begin
                if (rseed < 0 || d < rbest) begin
                    rseed = i;
                    rbest = d;
                end
            end
        end
        lmask = grow_cluster(lseed);
        rmask = grow_cluster(rseed);
        for (int i = 0; i < stored; i++) begin
            lab.cone_number = i[5:0];
            if (i == lseed) lab.side_label = LABEL_LEFT_SEED;
            else if (i == rseed) lab.side_label = LABEL_RIGHT_SEED;
            else if (lmask[i]) lab.side_label = LABEL_LEFT_MEMBER;
            else if (rmask[i]) lab.side_label = LABEL_RIGHT_MEMBER;
            else lab.side_label = LABEL_NONE;
            lab.pos_x = x_mem[i];
            lab.pos_y = y_mem[i];
            lab.frame_overflow = dropped;
            lab.result_last = (i == stored - 1);
            label_q = {label_q, lab};
        end
        stored  = 0;
        dropped = 0;
    endfunction

    function void note_cone(cone_in_t c);
        if (stored < MAX_CONES) begin
            x_mem[stored] = c.cone_x;
            y_mem[stored] = c.cone_y;
            stored++;
        end else begin
            dropped = 1;
        end
        if (c.frame_end) predict_frame();
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_label(label_out_t got);
        label_out_t want;
        if (label_q.size() == 0) begin
            report($sformatf("unexpected label for cone %0d", got.cone_number));
            return;
        end
        want = label_q.pop_front();
        if (got.cone_number !== want.cone_number)
            report($sformatf("cone_number %0d, want %0d", got.cone_number, want.cone_number));
        if (got.side_label !== want.side_label)
            report($sformatf("cone %0d side_label %0d, want %0d", want.cone_number,
                             got.side_label, want.side_label));
        if (got.pos_x !== want.pos_x)
            report($sformatf("cone %0d pos_x %0d, want %0d", want.cone_number,
                             got.pos_x, want.pos_x));
        if (got.pos_y !== want.pos_y)
            report($sformatf("cone %0d pos_y %0d, want %0d", want.cone_number,
                             got.pos_y, want.pos_y));
        if (got.frame_overflow !== want.frame_overflow)
            report($sformatf("cone %0d frame_overflow %0b, want %0b", want.cone_number,
                             got.frame_overflow, want.frame_overflow));
        if (got.result_last !== want.result_last)
            report($sformatf("cone %0d result_last %0b, want %0b", want.cone_number,
                             got.result_last, want.result_last));
    endtask
endclass

module tb_top;
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    cone_in_t             s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    label_out_t           m_data;
    logic                 cfg_we = 1'b0;
    logic [LINK_BITS-1:0] cfg_data = '0;

    label_scoreboard labels = new();
    bit              quiet = 0;
    bit              hold_req = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    cone_side_cluster_labeler i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data)
    );

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) labels.check_label(m_data);
    end

    // Result side: random stall bursts, plus one long hold on request.
    initial begin
        int stall_cycles;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_ready <= 1'b0;
                stall_cycles = 0;
                while (stall_cycles < 400) begin
                    @(negedge aclk);
                    stall_cycles++;
                end
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task send_cone(input logic signed [COORD_BITS-1:0] x, input logic signed [COORD_BITS-1:0] y,
                   input bit last);
        cone_in_t c;
        c.cone_x = x;
        c.cone_y = y;
        c.frame_end = last;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        labels.note_cone(c);
        @(negedge aclk);
    endtask

    task wait_drained();
        while (labels.pending() != 0) @(negedge aclk);
        s_valid <= 1'b0;
        repeat (20) @(negedge aclk);
    endtask

    task write_link(input logic [LINK_BITS-1:0] v);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        labels.link = v;
        @(negedge aclk);
    endtask

    // A frame of n cones; wide frames use the full coordinate range, others cluster near zero.
    task random_frame(input int n, input bit wide);
        logic signed [COORD_BITS-1:0] x, y;
        for (int i = 0; i < n; i++) begin
            if (wide) begin
                x = COORD_BITS'($urandom);
                y = COORD_BITS'($urandom);
            end else begin
                x = COORD_BITS'($urandom_range(0, 6000) - 3000);
                y = COORD_BITS'($urandom_range(0, 6000) - 3000);
            end
            send_cone(x, y, i == n - 1);
        end
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed frames at the reset link distance: seeds, ties, origin, extremes.
        send_cone(500, 0, 0);
        send_cone(0, -500, 0);
        send_cone(500, 0, 0);
        send_cone(-200, 50, 0);
        send_cone(0, 0, 0);
        send_cone(1200, -300, 1);
        send_cone(400, 300, 0);
        send_cone(300, 400, 0);
        send_cone(300, -400, 0);
        send_cone(400, -300, 1);
        send_cone(-5, -5, 1);
        send_cone(-32768, -32768, 0);
        send_cone(32767, 32767, 0);
        send_cone(-32768, 32767, 0);
        send_cone(32767, -32768, 0);
        send_cone(0, -1, 0);
        send_cone(1, 0, 1);

        // A hop length of zero links only coincident cones.
        write_link('0);
        send_cone(100, 100, 0);
        send_cone(100, 100, 0);
        send_cone(100, -100, 0);
        send_cone(100, -100, 1);

        write_link(15'h7FFF);
        random_frame(6, 1);
        random_frame(64, 1);

        // Overflow frame: the frame end rides on a dropped cone.
        write_link(15'd200);
        random_frame(70, 1);

        // Long result stall while cones keep coming.
        hold_req = 1;
        for (int k = 0; k < 6; k++) random_frame($urandom_range(1, 8), 0);

        for (int p = 0; p < 4; p++) begin
            write_link(p == 0 ? 15'd1500 : 15'($urandom_range(0, 4000)));
            for (int k = 0; k < 3; k++) random_frame($urandom_range(1, 8), $urandom_range(0, 3) == 0);
        end

        quiet = 1;
        for (int k = 0; k < 6; k++) random_frame($urandom_range(1, 8), 0);

        wait_drained();
        repeat (50) @(negedge aclk);
        if (labels.errors == 0 && labels.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
